// ===== rtl/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the S-record parser
// Line phases, result kinds, character codes and the hex digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    localparam int ADDR_BITS_DEF = 32;

    // character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_3  = 8'h33;

    // configuration register select (paddr bit 3)
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    localparam logic [32:0] WIN_SIZE_RST = 33'h0_0001_0000;

    typedef enum logic [3:0] {
        PH_START,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_TAIL,
        PH_IGNORE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_END     = 2'd1,
        KIND_IGNORED = 2'd2,
        KIND_BAD     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] base;
        logic [32:0] size;
    } t_window;

    typedef struct packed {
        logic       valid;
        logic [7:0] char_in;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] mem_offset;
        logic [7:0]  data_byte;
        logic [7:0]  data_count;
    } t_result;

    // {ok, value}; ok low for a non-hex character
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// srp_apb_regs: configuration registers
// Window base at byte address 0, window size at byte address 8.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_apb_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_psel,
    input  wire logic            i_penable,
    input  wire logic            i_pwrite,
    input  wire logic [3:0]      i_paddr,
    input  wire logic [63:0]     i_pwdata,
    output logic [63:0]          o_prdata,
    output logic                 o_pready,
    output srp_pkg::t_window     o_win
);
    import srp_pkg::*;

    logic [31:0] r_base;
    logic [32:0] r_size;
    logic        wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= WIN_SIZE_RST;
        end else if (wr_en) begin
            if (i_paddr[3] == REG_BASE) begin
                r_base <= i_pwdata[31:0];
            end else begin
                r_size <= i_pwdata[32:0];
            end
        end
    end

    always_comb begin
        if (i_paddr[3] == REG_SIZE) begin
            o_prdata = {31'd0, r_size};
        end else begin
            o_prdata = {32'd0, r_base};
        end
    end

    assign o_win.base = r_base;
    assign o_win.size = r_size;

endmodule

`default_nettype wire

// ===== rtl/srp_in_reg.sv =====
// ----------------------------------------------------------------------------
// srp_in_reg: input word register
// Holds one character until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_in_reg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [7:0]   i_data,
    output logic              o_ready,
    input  wire logic         i_take,
    output srp_pkg::t_in_word o_word
);
    import srp_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_data;
        end
    end

    assign o_word.valid   = r_valid;
    assign o_word.char_in = r_char;

endmodule

`default_nettype wire

// ===== rtl/srp_decoder.sv =====
// ----------------------------------------------------------------------------
// srp_decoder: per-character record decode
// Line state machine, address/count tracking, window test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_decoder #(
    parameter int ADDR_BITS = srp_pkg::ADDR_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  srp_pkg::t_in_word  i_word,
    input  srp_pkg::t_window   i_win,
    output logic               o_take,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output srp_pkg::t_result   o_res
);
    import srp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_rtype, n_rtype;
    logic [3:0]             r_dcount, n_dcount;
    logic [3:0]             r_hi, n_hi;
    logic [7:0]             r_left, n_left;
    logic [7:0]             r_rbytes, n_rbytes;
    logic [ADDR_BITS-1:0]   r_accum, n_accum;
    logic [ADDR_BITS-1:0]   r_start, n_start;
    logic                   r_skip, n_skip;
    logic                   r_res_valid, n_res_valid;
    t_result                r_res, n_res;

    logic                   adv;
    logic                   go;
    logic [7:0]             c;
    logic [4:0]             hx;
    logic [3:0]             dc_inc;
    logic [3:0]             need_digits;
    logic [7:0]             cnt;
    logic [7:0]             need_bytes;
    logic [32:0]            diff;
    logic                   in_win;

    assign adv    = !r_res_valid || i_res_ready;
    assign go     = i_word.valid && adv;
    assign o_take = go;
    assign c      = i_word.char_in;
    assign hx     = hex_decode(c);

    assign dc_inc      = r_dcount + 4'd1;
    assign need_digits = {1'b0, r_rtype, 1'b0} + 4'd2;
    assign cnt         = {r_hi, hx[3:0]};
    assign need_bytes  = {6'd0, r_rtype} + 8'd2;
    assign diff        = {1'b0, 32'(r_accum)} - {1'b0, i_win.base};
    assign in_win      = !diff[32] && ({1'b0, diff[31:0]} < i_win.size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_rtype     <= '0;
            r_dcount    <= '0;
            r_hi        <= '0;
            r_left      <= '0;
            r_rbytes    <= '0;
            r_accum     <= '0;
            r_start     <= '0;
            r_skip      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_rtype     <= n_rtype;
            r_dcount    <= n_dcount;
            r_hi        <= n_hi;
            r_left      <= n_left;
            r_rbytes    <= n_rbytes;
            r_accum     <= n_accum;
            r_start     <= n_start;
            r_skip      <= n_skip;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_rtype     = r_rtype;
        n_dcount    = r_dcount;
        n_hi        = r_hi;
        n_left      = r_left;
        n_rbytes    = r_rbytes;
        n_accum     = r_accum;
        n_start     = r_start;
        n_skip      = r_skip;
        n_res_valid = adv ? 1'b0 : r_res_valid;
        n_res       = '0;

        if (go) begin
            if (c == CH_LF) begin
                n_phase  = PH_START;
                n_dcount = '0;
                if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    n_res_valid = 1'b1;
                    case (r_phase)
                        PH_TAIL: begin
                            n_res.kind       = KIND_END;
                            n_res.mem_offset = 32'(r_start);
                            n_res.data_count = r_rbytes;
                        end
                        PH_COUNT, PH_ADDR, PH_DATA: n_res.kind = KIND_BAD;
                        default: n_res.kind = KIND_IGNORED;
                    endcase
                end
            end else if (!r_skip) begin
                case (r_phase)
                    PH_START: begin
                        n_phase = (c == CH_S) ? PH_TYPE : PH_IGNORE;
                    end
                    PH_TYPE: begin
                        if (c inside {[CH_1:CH_3]}) begin
                            n_rtype  = c[1:0];
                            n_dcount = '0;
                            n_phase  = PH_COUNT;
                        end else begin
                            n_phase = PH_IGNORE;
                        end
                    end
                    PH_COUNT, PH_ADDR, PH_DATA: begin
                        if (!hx[4]) begin
                            // bad digit: report and drop the rest of the line
                            n_skip      = 1'b1;
                            n_phase     = PH_IGNORE;
                            n_res_valid = 1'b1;
                            n_res.kind  = KIND_BAD;
                        end else if (r_phase == PH_COUNT) begin
                            if (r_dcount == 4'd0) begin
                                n_hi     = hx[3:0];
                                n_dcount = 4'd1;
                            end else if (cnt < need_bytes) begin
                                n_skip      = 1'b1;
                                n_phase     = PH_IGNORE;
                                n_res_valid = 1'b1;
                                n_res.kind  = KIND_BAD;
                            end else begin
                                n_left   = cnt - need_bytes;
                                n_rbytes = cnt - need_bytes;
                                n_accum  = '0;
                                n_dcount = '0;
                                n_phase  = PH_ADDR;
                            end
                        end else if (r_phase == PH_ADDR) begin
                            n_accum  = {r_accum[ADDR_BITS-5:0], hx[3:0]};
                            n_dcount = dc_inc;
                            if (dc_inc >= need_digits) begin
                                n_start  = n_accum;
                                n_dcount = '0;
                                n_phase  = (r_left != 8'd0) ? PH_DATA : PH_TAIL;
                            end
                        end else begin
                            if (r_dcount == 4'd0) begin
                                n_hi     = hx[3:0];
                                n_dcount = 4'd1;
                            end else begin
                                n_dcount = '0;
                                if (in_win) begin
                                    n_res_valid      = 1'b1;
                                    n_res.kind       = KIND_WRITE;
                                    n_res.mem_offset = diff[31:0];
                                    n_res.data_byte  = cnt;
                                end
                                // address advances for every byte, in window or not
                                n_accum = r_accum + ADDR_BITS'(1);
                                n_left  = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    n_phase = PH_TAIL;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/srec_record_parser.sv =====
// ----------------------------------------------------------------------------
// srec_record_parser: S1/S2/S3 record decoder
// Turns a character stream into window-relative memory writes and record
// reports.
//
//   channel  direction  words
//   s_*      in         one text character per word (0x0A ends a line)
//   m_*      out        data write, record end, line ignored or malformed
//   APB      in/out     window base (addr 0), window size (addr 8)
//
// One character per cycle while the result side is not stalled; a character goes
// through the input register and the decoder into the result register.
// The line state updates in the same cycle the decoder takes a word.
// Reset returns the parser to start of line with a 64 KiB window at 0.
// A stalled result holds the decoder; one more word waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_record_parser #(
    parameter int ADDR_BITS = srp_pkg::ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [31:0] mem_offset, [39:32] data_byte,
                                          // [47:40] data_count
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import srp_pkg::*;

    t_window  win;
    t_in_word in_word;
    t_result  res;
    logic     take;

    srp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_win     (win)
    );

    srp_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ready (o_s_tready),
        .i_take  (take),
        .o_word  (in_word)
    );

    srp_decoder #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (in_word),
        .i_win       (win),
        .o_take      (take),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {res.data_count, res.data_byte, res.mem_offset};
    assign o_m_tuser = res.kind;

endmodule

`default_nettype wire

// ===== verif/srec_record_parser_tb.sv =====
// ----------------------------------------------------------------------------
// srec_record_parser_tb: self-checking bench for the S-record parser
// Streams character lines into the parser (well-formed S1/S2/S3 records,
// broken records, foreign lines and raw noise) under several window
// settings. A line-state predictor works out each expected result word, and
// every word from the master side is compared field by field. Both stream
// sides idle at random, and the sink holds off once long enough to back up
// the input.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_record_parser_tb;

    import srp_pkg::*;

    localparam logic [3:0] ADDR_WIN_BASE = {REG_BASE, 3'b000};
    localparam logic [3:0] ADDR_WIN_SIZE = {REG_SIZE, 3'b000};

    // Tracks the parser's line state and window; holds the expected words.
    class srec_window_tracker;
        logic [31:0] win_base;
        logic [32:0] win_size;
        t_phase      phase;
        logic [1:0]  rec_type;
        logic [3:0]  nib_count;
        logic [3:0]  high_nib;
        logic [7:0]  bytes_togo;
        logic [7:0]  rec_len;
        logic [31:0] cur_addr;
        logic [31:0] rec_addr;
        bit          skip_rest;
        t_result     pending_words[$];
        int          mismatch_count;

        function new();
            win_base = '0;
            win_size = WIN_SIZE_RST;
            phase = PH_START;
            rec_type = '0;
            nib_count = '0;
            high_nib = '0;
            bytes_togo = '0;
            rec_len = '0;
            cur_addr = '0;
            rec_addr = '0;
            skip_rest = 1'b0;
            mismatch_count = 0;
        endfunction

        // {ok, value}
        static function logic [4:0] nib_of(logic [7:0] c);
            if (c >= "0" && c <= "9") begin
                return {1'b1, c[3:0]};
            end
            if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
                return {1'b1, 4'(c[3:0] + 4'd9)};
            end
            return 5'd0;
        endfunction

        function void set_reg(logic sel, logic [63:0] value);
            if (sel == REG_BASE) begin
                win_base = value[31:0];
            end else begin
                win_size = value[32:0];
            end
        endfunction

        function void add_word(t_kind k, logic [31:0] off, logic [7:0] b, logic [7:0] n);
            t_result w;
            w.kind = k;
            w.mem_offset = off;
            w.data_byte = b;
            w.data_count = n;
            pending_words.push_back(w);
        endfunction

        function void give_up_line();
            skip_rest = 1'b1;
            phase = PH_IGNORE;
            add_word(KIND_BAD, '0, '0, '0);
        endfunction

        function void take_char(logic [7:0] c);
            t_phase      was;
            logic [4:0]  hv;
            logic [7:0]  cnt;
            logic [7:0]  need;
            logic [7:0]  byte_val;
            logic [32:0] rel;
            was = phase;
            if (c == CH_LF) begin
                phase = PH_START;
                nib_count = '0;
                if (skip_rest) begin
                    skip_rest = 1'b0;
                end else if (was == PH_TAIL) begin
                    add_word(KIND_END, rec_addr, '0, rec_len);
                end else if (was == PH_COUNT || was == PH_ADDR || was == PH_DATA) begin
                    add_word(KIND_BAD, '0, '0, '0);
                end else begin
                    add_word(KIND_IGNORED, '0, '0, '0);
                end
                return;
            end
            if (skip_rest) return;
            case (was)
                PH_START: begin
                    phase = (c == CH_S) ? PH_TYPE : PH_IGNORE;
                end
                PH_TYPE: begin
                    if (c >= CH_1 && c <= CH_3) begin
                        rec_type = c[1:0];
                        nib_count = '0;
                        phase = PH_COUNT;
                    end else begin
                        phase = PH_IGNORE;
                    end
                end
                PH_COUNT, PH_ADDR, PH_DATA: begin
                    hv = nib_of(c);
                    if (!hv[4]) begin
                        give_up_line();
                    end else if (was == PH_COUNT) begin
                        if (nib_count == 0) begin
                            high_nib = hv[3:0];
                            nib_count = 4'd1;
                        end else begin
                            cnt = {high_nib, hv[3:0]};
                            need = 8'(rec_type) + 8'd2;
                            if (cnt < need) begin
                                give_up_line();
                            end else begin
                                bytes_togo = cnt - need;
                                rec_len = bytes_togo;
                                cur_addr = '0;
                                nib_count = '0;
                                phase = PH_ADDR;
                            end
                        end
                    end else if (was == PH_ADDR) begin
                        cur_addr = {cur_addr[27:0], hv[3:0]};
                        nib_count = nib_count + 4'd1;
                        if (int'(nib_count) >= 2 * (int'(rec_type) + 1)) begin
                            rec_addr = cur_addr;
                            nib_count = '0;
                            phase = (bytes_togo != 0) ? PH_DATA : PH_TAIL;
                        end
                    end else if (nib_count == 0) begin
                        high_nib = hv[3:0];
                        nib_count = 4'd1;
                    end else begin
                        byte_val = {high_nib, hv[3:0]};
                        nib_count = '0;
                        rel = {1'b0, cur_addr} - {1'b0, win_base};
                        if (cur_addr >= win_base && rel < win_size) begin
                            add_word(KIND_WRITE, rel[31:0], byte_val, '0);
                        end
                        cur_addr = cur_addr + 32'd1;
                        bytes_togo = bytes_togo - 8'd1;
                        if (bytes_togo == 0) phase = PH_TAIL;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [1:0] kind_bits, logic [47:0] data);
            t_result want;
            if (pending_words.size() == 0) begin
                $error("unexpected result word: kind %0d, tdata %h", kind_bits, data);
                mismatch_count++;
                return;
            end
            want = pending_words.pop_front();
            if (kind_bits !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind_bits);
                mismatch_count++;
            end
            if (data[31:0] !== want.mem_offset) begin
                $error("mem_offset: expected %h, got %h", want.mem_offset, data[31:0]);
                mismatch_count++;
            end
            if (data[39:32] !== want.data_byte) begin
                $error("data_byte: expected %h, got %h", want.data_byte, data[39:32]);
                mismatch_count++;
            end
            if (data[47:40] !== want.data_count) begin
                $error("data_count: expected %0d, got %0d", want.data_count, data[47:40]);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] char_in
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [31:0] mem_offset, [39:32] data_byte, [47:40] data_count
    logic [1:0]  o_m_tuser;   // [1:0] kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    srec_window_tracker board = new();
    bit          steady;
    bit          hold_req;
    logic [7:0]  line_buf[$];

    srec_record_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #3000000;
        $display("srec_record_parser_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_word(o_m_tuser, o_m_tdata);
        end
    end

    // Sink side: random stalls, plus one long hold-off on request.
    initial begin : sink
        int hold_left;
        hold_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 200;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (steady) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = ($urandom_range(0, 99) >= 14);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.take_char(c);
    endtask

    // Drop valid, drain every expected word, then let the pipeline empty.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_reg(addr[3], value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Upper bits beyond each register's width are junk and must be dropped.
    task automatic set_window(input logic [31:0] base, input logic [32:0] size);
        apb_write(ADDR_WIN_BASE, {32'($urandom), base});
        apb_write(ADDR_WIN_SIZE, {31'($urandom), size});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic void put_hex(input logic [31:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--) begin
            line_buf.push_back(hex_char(v[4 * i +: 4]));
        end
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        logic [4:0] hv;
        do begin
            c = 8'($urandom);
            hv = srec_window_tracker::nib_of(c);
        end while (c == CH_LF || hv[4]);
        return c;
    endfunction

    function automatic logic [7:0] non_lf_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_LF);
        return c;
    endfunction

    function automatic logic [31:0] pick_addr(input int rtype);
        logic [31:0] mask;
        logic [31:0] a;
        int          roll;
        int          span;
        mask = (rtype == 1) ? 32'h0000_FFFF : (rtype == 2) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
        span = (board.win_size > 64) ? 64 : int'(board.win_size);
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            a = board.win_base + 32'($urandom_range(0, span + 8)) - 32'd4;
        end else if (roll < 55) begin
            a = board.win_base + board.win_size[31:0] - 32'($urandom_range(0, 6));
        end else if (roll < 65) begin
            a = mask - 32'($urandom_range(0, 8));
        end else begin
            a = $urandom;
        end
        return a & mask;
    endfunction

    // Build one well-formed record into line_buf (no newline yet).
    function automatic void build_record();
        int         rtype;
        int         abytes;
        int         ndata;
        logic [7:0] cnt;
        rtype = $urandom_range(1, 3);
        abytes = rtype + 1;
        if ($urandom_range(0, 19) == 0) begin
            ndata = $urandom_range(13, 254 - abytes);
        end else begin
            ndata = $urandom_range(0, 12);
        end
        cnt = 8'(abytes + 1 + ndata);
        line_buf.push_back(CH_S);
        line_buf.push_back(8'h30 + 8'(rtype));
        put_hex(32'(cnt), 2);
        put_hex(pick_addr(rtype), 2 * abytes);
        repeat (ndata) put_hex($urandom, 2);
        put_hex($urandom, 2);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(non_lf_char());
        end
    endfunction

    function automatic void build_line();
        int         roll;
        int         pos;
        int         keep;
        logic [7:0] cnt;
        logic [7:0] c;
        line_buf.delete();
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            build_record();
        end else if (roll < 80) begin
            build_record();
            case ($urandom_range(0, 2))
                0: begin
                    // count one short of address plus checksum, or lower
                    cnt = 8'($urandom_range(0, int'(line_buf[1] - 8'h30) + 1));
                    line_buf[2] = hex_char(cnt[7:4]);
                    line_buf[3] = hex_char(cnt[3:0]);
                end
                1: begin
                    pos = $urandom_range(2, line_buf.size() - 1);
                    line_buf[pos] = junk_char();
                end
                default: begin
                    keep = $urandom_range(2, line_buf.size() - 3);
                    while (line_buf.size() > keep) void'(line_buf.pop_back());
                end
            endcase
        end else if (roll < 90) begin
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(CH_S);
                do c = non_lf_char(); while (c >= CH_1 && c <= CH_3);
                line_buf.push_back(c);
            end else begin
                do c = non_lf_char(); while (c == CH_S);
                line_buf.push_back(c);
            end
            repeat ($urandom_range(0, 10)) line_buf.push_back(non_lf_char());
        end else begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
        end
        line_buf.push_back(CH_LF);
    endfunction

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic random_lines(input int quota);
        int sent;
        sent = 0;
        while (sent < quota) begin
            build_line();
            foreach (line_buf[i]) send_char(line_buf[i]);
            sent += line_buf.size();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset window: data record, empty line, lone S, short count,
        // bad digit, newline inside the address
        send_string("S1040010aB\n");
        send_string("\n");
        send_string("S\n");
        send_string("S102\n");
        send_string("S1G\n");
        send_string("S104\n");
        random_lines(250);
        settle();

        set_window(32'h0000_1000, 33'h0_0000_0100);
        hold_req = 1'b1;
        random_lines(300);
        settle();

        set_window(32'hFFFF_FFF0, 33'h1_0000_0000);
        steady = 1'b1;
        random_lines(300);
        steady = 1'b0;
        settle();

        set_window(32'h0000_0000, 33'h0_0000_0000);
        random_lines(300);
        settle();

        set_window($urandom, 33'($urandom_range(1, 512)));
        random_lines(300);
        settle();

        set_window(32'h0000_0000, 33'h1_0000_0000);
        random_lines(300);
        settle();

        if (board.mismatch_count == 0 && board.pending_words.size() == 0) begin
            $display("srec_record_parser_tb passed");
        end else begin
            $display("srec_record_parser_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
